@@ rtl/lfps_pkg.sv @@
// Shared types and constants of the five-point Laplacian stencil unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package lfps_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int RESULT_W        = 48;
    localparam int GRID_SIDE_W     = 6;
    localparam int GRID_SIDE_RESET = 10;
    localparam int MIN_SIDE        = 2;
    localparam int MAX_SIDE_DEF    = 32;

    // 4*c - l - r - u - d of 32-bit samples stays inside 35 signed bits
    localparam int SUM_W = 35;

    localparam int QUEUE_DEPTH = 4;

    // row buffer slots of the line store
    localparam int SLOT_W = 2;
    localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_B = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_C = 2'd2;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/laplacian_five_point_stencil_unit.sv @@
// Top level of the five-point Laplacian stencil unit: front end, command queue, back end.
// Depends on lfps_pkg, lfps_front, lfps_cmd_queue and lfps_back.
//
//   channel   handshake            payload
//   input     push / full          i_sample       (signed Q16.16, raster order)
//   result    empty / pop          o_result, o_frame_last
//   config    i_cfg_we             i_cfg_data     (grid side, restarts the frame)
//
// One sample per cycle while results are taken; a point's word reaches the result ports
// through the store read and sum stage, the queue and the scale register once the sample of the row below is taken.
// After the last sample the final row is replayed from the three-row line store, one
// result a cycle while the queue has room, overlapped with the next frame's first row;
// the last sample of that row waits for the replay.
// Reset needs no clearing pass; past row 0, full rises once the command queue has one free slot.
`default_nettype none

module laplacian_five_point_stencil_unit #(
    parameter int MAX_SIDE = lfps_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [lfps_pkg::GRID_SIDE_W-1:0]       i_cfg_data,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [lfps_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [lfps_pkg::RESULT_W-1:0]        o_result,
    output logic                                        o_frame_last
);

    localparam int SCW = $clog2((MAX_SIDE + 1) * (MAX_SIDE + 1) + 1);

    logic           q_push;
    logic           q_pop;
    logic           q_avail;
    logic           q_room2;
    lfps_pkg::t_cmd q_cmd;
    lfps_pkg::t_cmd q_head;
    logic [SCW-1:0] scale;

    lfps_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_sample   (i_sample),
        .o_full     (full),
        .i_q_room2  (q_room2),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd),
        .o_scale    (scale)
    );

    lfps_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_avail (q_avail),
        .o_room2 (q_room2)
    );

    lfps_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_avail    (q_avail),
        .i_head       (q_head),
        .o_q_pop      (q_pop),
        .i_scale      (scale),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

@@ rtl/lfps_cmd_queue.sv @@
// Short command queue between the stencil front end and the scaling back end.
// Depends on lfps_pkg (t_cmd, QUEUE_DEPTH).
`default_nettype none

module lfps_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lfps_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output lfps_pkg::t_cmd     o_head,
    output logic               o_avail,
    output logic               o_room2
);

    localparam int QW = $clog2(lfps_pkg::QUEUE_DEPTH);

    lfps_pkg::t_cmd r_mem [lfps_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wr;
    logic [QW-1:0]  r_rd;
    logic [QW:0]    r_count;
    logic [QW:0]    n_count;

    assign o_head  = r_mem[r_rd];
    assign o_avail = (r_count != '0);
    assign o_room2 = (r_count <= (QW+1)'(lfps_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < (QW+1)'(lfps_pkg::QUEUE_DEPTH) || i_pop))
        else $error("command queue overflow");

endmodule

`default_nettype wire

@@ rtl/lfps_front.sv @@
// Front end: side register, raster counters, three-row line store and stencil sums.
// Depends on lfps_pkg; feeds lfps_cmd_queue with one summed stencil per grid point.
`default_nettype none

module lfps_front #(
    parameter int MAX_SIDE = lfps_pkg::MAX_SIDE_DEF,
    localparam int SCW = $clog2((MAX_SIDE + 1) * (MAX_SIDE + 1) + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lfps_pkg::GRID_SIDE_W-1:0]    i_cfg_data,
    input  wire logic                                i_push,
    input  wire logic signed [lfps_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_full,
    input  wire logic                                i_q_room2,
    output logic                                     o_q_push,
    output lfps_pkg::t_cmd                           o_q_cmd,
    output logic [SCW-1:0]                           o_scale
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int PW2 = 2 * (SW + 1);
    localparam int AW  = lfps_pkg::SLOT_W + CW;
    localparam int MEM_DEPTH = 3 * (2 ** CW);
    localparam int RST_SIDE =
        (lfps_pkg::GRID_SIDE_RESET < lfps_pkg::MIN_SIDE) ? lfps_pkg::MIN_SIDE :
        (lfps_pkg::GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : lfps_pkg::GRID_SIDE_RESET;
    localparam int RST_SCALE = (RST_SIDE + 1) * (RST_SIDE + 1);
    localparam int SUM_W = lfps_pkg::SUM_W;
    localparam int DW    = lfps_pkg::SAMPLE_W;

    // configuration
    logic [SW-1:0]                   r_side;
    logic [SCW-1:0]                  r_scale;
    logic [lfps_pkg::GRID_SIDE_W-1:0] cfg_clamp;
    logic [SW:0]                     cfg_p1;
    logic [PW2-1:0]                  cfg_p1_ext;
    logic [PW2-1:0]                  cfg_sq;

    // raster position and row slots
    logic [CW-1:0]                   r_col;
    logic [CW-1:0]                   r_row;
    logic [lfps_pkg::SLOT_W-1:0]     r_slot_cur;
    logic [lfps_pkg::SLOT_W-1:0]     r_slot_prev;
    logic [lfps_pkg::SLOT_W-1:0]     r_slot_up;

    // final row replay
    logic                            r_fl_active;
    logic [CW-1:0]                   r_fl_col;
    logic [lfps_pkg::SLOT_W-1:0]     r_fl_prev;
    logic [lfps_pkg::SLOT_W-1:0]     r_fl_up;

    // line store and read stage
    logic [DW-1:0]                   r_store [MEM_DEPTH];
    logic signed [DW-1:0]            r_rd_p;
    logic signed [DW-1:0]            r_rd_u;
    logic [AW-1:0]                   n_pa;
    logic [AW-1:0]                   n_ua;

    // sum stage
    logic                            r_b_valid;
    logic                            r_b_emit;
    logic                            r_b_first;
    logic                            r_b_lastc;
    logic                            r_b_upv;
    logic                            r_b_last;
    logic signed [DW-1:0]            r_b_x;
    logic signed [DW-1:0]            r_win_l;
    logic signed [DW-1:0]            r_win_c;
    logic signed [DW-1:0]            b_left;
    logic signed [DW-1:0]            b_right;
    logic signed [DW-1:0]            b_up;
    logic signed [SUM_W-1:0]         b_sum;

    logic                            s_lastc;
    logic                            s_lastr;
    logic                            f_lastc;
    logic                            s_ok;
    logic                            s_acc;
    logic                            s_step;
    logic                            f_issue;

    assign cfg_clamp =
        (i_cfg_data < lfps_pkg::GRID_SIDE_W'(lfps_pkg::MIN_SIDE)) ?
            lfps_pkg::GRID_SIDE_W'(lfps_pkg::MIN_SIDE) :
        (i_cfg_data > lfps_pkg::GRID_SIDE_W'(MAX_SIDE)) ?
            lfps_pkg::GRID_SIDE_W'(MAX_SIDE) : i_cfg_data;
    assign cfg_p1     = (SW+1)'(cfg_clamp) + (SW+1)'(1);
    assign cfg_p1_ext = PW2'(cfg_p1);
    assign cfg_sq     = cfg_p1_ext * cfg_p1_ext;
    assign o_scale    = r_scale;

    assign s_lastc = (SW'(r_col) == r_side - SW'(1));
    assign s_lastr = (SW'(r_row) == r_side - SW'(1));
    assign f_lastc = (SW'(r_fl_col) == r_side - SW'(1));

    // row 0 makes no command; its last sample needs the read ports after the replay
    assign s_ok    = (r_row == '0) ? !(s_lastc && r_fl_active) : i_q_room2;
    assign o_full  = !s_ok;
    assign s_acc   = i_push && s_ok;
    assign s_step  = s_acc && ((r_row != '0) || s_lastc);
    assign f_issue = r_fl_active && i_q_room2;

    always_comb begin
        if (f_issue) begin
            n_pa = f_lastc ? {r_fl_prev, CW'(0)} : {r_fl_prev, CW'(r_fl_col + CW'(1))};
            n_ua = {r_fl_up, r_fl_col};
        end else begin
            n_pa = s_lastc ? {r_slot_cur, CW'(0)} : {r_slot_prev, CW'(r_col + CW'(1))};
            n_ua = {r_slot_up, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SW'(RST_SIDE);
            r_scale     <= SCW'(RST_SCALE);
            r_col       <= '0;
            r_row       <= '0;
            r_slot_cur  <= lfps_pkg::SLOT_A;
            r_slot_prev <= lfps_pkg::SLOT_B;
            r_slot_up   <= lfps_pkg::SLOT_C;
            r_fl_active <= 1'b0;
            r_fl_col    <= '0;
            r_fl_prev   <= lfps_pkg::SLOT_A;
            r_fl_up     <= lfps_pkg::SLOT_B;
            r_b_valid   <= 1'b0;
            r_b_emit    <= 1'b0;
        end else begin
            if (f_issue) begin
                if (f_lastc) begin
                    r_fl_active <= 1'b0;
                end else begin
                    r_fl_col <= r_fl_col + CW'(1);
                end
            end
            if (i_cfg_we) begin
                r_side      <= SW'(cfg_clamp);
                r_scale     <= SCW'(cfg_sq);
                r_col       <= '0;
                r_row       <= '0;
                r_fl_active <= 1'b0;
            end else if (s_acc) begin
                if (s_lastc) begin
                    r_col       <= '0;
                    r_slot_cur  <= r_slot_up;
                    r_slot_prev <= r_slot_cur;
                    r_slot_up   <= r_slot_prev;
                    if (s_lastr) begin
                        r_row       <= '0;
                        r_fl_active <= 1'b1;
                        r_fl_col    <= '0;
                        r_fl_prev   <= r_slot_cur;
                        r_fl_up     <= r_slot_prev;
                    end else begin
                        r_row <= r_row + CW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            r_b_valid <= f_issue || s_step;
            r_b_emit  <= f_issue || (s_acc && (r_row != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_store[{r_slot_cur, r_col}] <= i_sample;
        end
        r_rd_p <= r_store[n_pa];
        r_rd_u <= r_store[n_ua];
        if (f_issue) begin
            r_b_first <= (r_fl_col == '0);
            r_b_lastc <= f_lastc;
            r_b_upv   <= 1'b1;
            r_b_last  <= f_lastc;
            r_b_x     <= '0;
        end else begin
            r_b_first <= (r_col == '0);
            r_b_lastc <= s_lastc;
            r_b_upv   <= (r_row > CW'(1));
            r_b_last  <= 1'b0;
            r_b_x     <= i_sample;
        end
        // slide the window; at a row end hold the prefetched first column
        if (r_b_valid) begin
            if (!r_b_lastc) begin
                r_win_l <= r_win_c;
            end
            r_win_c <= r_rd_p;
        end
    end

    assign b_left  = r_b_first ? '0 : r_win_l;
    assign b_right = r_b_lastc ? '0 : r_rd_p;
    assign b_up    = r_b_upv ? r_rd_u : '0;
    assign b_sum   = (SUM_W'(r_win_c) <<< 2) - SUM_W'(b_left) - SUM_W'(b_right)
                     - SUM_W'(b_up) - SUM_W'(r_b_x);

    assign o_q_push     = r_b_valid && r_b_emit;
    assign o_q_cmd.sum  = b_sum;
    assign o_q_cmd.last = r_b_last;

    a_slots_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_cur != r_slot_prev) && (r_slot_cur != r_slot_up)
        && (r_slot_prev != r_slot_up))
        else $error("line store row slots overlap");

    a_replay_in_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl_active |-> (r_row == '0))
        else $error("final row replay overlaps a row that reads the store");

    a_replay_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl_active |-> (SW'(r_fl_col) < r_side))
        else $error("final row replay column out of range");

endmodule

`default_nettype wire

@@ rtl/lfps_back.sv @@
// Back end: scales each stencil sum by (side+1)^2 and holds the result for the consumer.
// Depends on lfps_pkg; pulls commands from lfps_cmd_queue.
`default_nettype none

module lfps_back #(
    parameter int MAX_SIDE = lfps_pkg::MAX_SIDE_DEF,
    localparam int SCW = $clog2((MAX_SIDE + 1) * (MAX_SIDE + 1) + 1)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_avail,
    input  wire lfps_pkg::t_cmd                        i_head,
    output logic                                       o_q_pop,
    input  wire logic [SCW-1:0]                        i_scale,
    input  wire logic                                  i_pop,
    output logic                                       o_empty,
    output logic signed [lfps_pkg::RESULT_W-1:0]       o_result,
    output logic                                       o_frame_last
);

    localparam int PW = lfps_pkg::SUM_W + SCW + 1;

    logic                                 r_valid;
    logic signed [lfps_pkg::RESULT_W-1:0] r_result;
    logic                                 r_last;
    logic signed [lfps_pkg::SUM_W-1:0]    h_sum;
    logic signed [SCW:0]                  scale_s;
    logic signed [PW-1:0]                 prod;
    logic                                 take;

    assign h_sum   = i_head.sum;
    assign scale_s = $signed({1'b0, i_scale});
    assign prod    = h_sum * scale_s;
    assign take    = i_q_avail && (!r_valid || i_pop);
    assign o_q_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= lfps_pkg::RESULT_W'(prod);
            r_last   <= i_head.last;
        end
    end

    assign o_empty      = !r_valid;
    assign o_result     = r_result;
    assign o_frame_last = r_last;

    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_avail && !r_valid) |=> r_valid)
        else $error("output register left empty with a command waiting");

endmodule

`default_nettype wire

@@ test/tb_laplacian_five_point_stencil_unit.sv @@
// Testbench for laplacian_five_point_stencil_unit: streams grids of several sides and
// checks every stencil word against a line-store predictor kept in the testbench.
// Depends on lfps_pkg and the RTL of the stencil unit.
`timescale 1ns / 100ps

module tb_laplacian_five_point_stencil_unit;

    localparam int SAMPLE_W      = lfps_pkg::SAMPLE_W;
    localparam int RESULT_W      = lfps_pkg::RESULT_W;
    localparam int GRID_SIDE_W   = lfps_pkg::GRID_SIDE_W;
    localparam int MIN_SIDE      = lfps_pkg::MIN_SIDE;
    localparam int SIDE_RESET    = lfps_pkg::GRID_SIDE_RESET;
    localparam int CLK_HALF      = 4;
    localparam int GRID_MAX      = lfps_pkg::MAX_SIDE_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 10000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 180;
    localparam int LARGE_ROWS    = 3;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                last;
    } t_stencil_word;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [GRID_SIDE_W-1:0]     i_cfg_data = '0;
    logic                       push       = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample   = '0;
    logic                       pop        = 1'b0;
    logic                       full;
    logic                       empty;
    logic signed [RESULT_W-1:0] o_result;
    logic                       o_frame_last;

    logic [GRID_SIDE_W-1:0]     side_setting = GRID_SIDE_W'(SIDE_RESET);
    logic signed [SAMPLE_W-1:0] line_store [0:2*GRID_MAX-1];
    int                         row_pos      = 0;
    int                         col_pos      = 0;
    t_stencil_word              pending_points [$];

    bit          tx_gaps       = 1'b1;
    bit          rx_stalls     = 1'b1;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    int          burst_left    = 0;
    int          mismatches    = 0;
    logic [15:0] stall_pattern = 16'hB5A3;
    logic [3:0]  stall_phase   = '0;

    laplacian_five_point_stencil_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result),
        .o_frame_last (o_frame_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int effective_side();
        if (side_setting < MIN_SIDE) return MIN_SIDE;
        if (side_setting > GRID_MAX) return GRID_MAX;
        return int'(side_setting);
    endfunction

    function automatic longint grid_value(int row, int col, int side);
        if (col < 0 || col >= side) return 0;
        return longint'(line_store[(row % 2) * GRID_MAX + col]);
    endfunction

    function automatic t_stencil_word stencil_point(longint centre, longint left,
                                                    longint right, longint up,
                                                    longint down, int side, bit last);
        longint        sum;
        longint        scaled;
        t_stencil_word w;
        sum    = 4 * centre - left - right - up - down;
        scaled = sum * longint'((side + 1) * (side + 1));
        w.value = scaled[RESULT_W-1:0];
        w.last  = last;
        return w;
    endfunction

    task automatic laplacian_predict(input logic signed [SAMPLE_W-1:0] x);
        int     side;
        int     r;
        int     c;
        longint up;
        side = effective_side();
        r    = row_pos;
        c    = col_pos;
        if (r >= side || c >= side) begin
            r = 0;
            c = 0;
        end
        if (r >= 1) begin
            up = (r >= 2) ? grid_value(r - 2, c, side) : 0;
            pending_points.push_back(stencil_point(grid_value(r - 1, c, side),
                grid_value(r - 1, c - 1, side), grid_value(r - 1, c + 1, side),
                up, longint'(x), side, 1'b0));
        end
        line_store[(r % 2) * GRID_MAX + c] = x;
        c++;
        if (c == side) begin
            c = 0;
            r++;
            if (r == side) begin
                for (int k = 0; k < side; k++) begin
                    pending_points.push_back(stencil_point(grid_value(side - 1, k, side),
                        grid_value(side - 1, k - 1, side), grid_value(side - 1, k + 1, side),
                        grid_value(side - 2, k, side), 0, side, k == side - 1));
                end
                r = 0;
            end
        end
        row_pos = r;
        col_pos = c;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push     <= 1'b1;
        i_sample <= x;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        laplacian_predict(x);
    endtask

    // hold off until every word is out and the pipeline has settled, then write
    task automatic write_grid_side(input logic [GRID_SIDE_W-1:0] v);
        push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        side_setting = v;
        row_pos      = 0;
        col_pos      = 0;
    endtask

    task automatic check_point();
        t_stencil_word want;
        if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected word: result=%h last=%b", o_result, o_frame_last);
            return;
        end
        want = pending_points.pop_front();
        if (o_result !== want.value || o_frame_last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: result exp %h got %h, last exp %b got %b",
                         want.value, o_result, want.last, o_frame_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) check_point();
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_stalls) begin
            pop <= stall_pattern[stall_phase];
            stall_phase++;
            if (stall_phase == 0) stall_pattern = 16'($urandom_range(1, 16'hFFFF));
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic test_reset_default();
        repeat (11) send_sample(random_sample());
    endtask

    task automatic test_restart_mid_frame();
        write_grid_side(GRID_SIDE_W'(3));
        repeat (4) send_sample(random_sample());
        write_grid_side(GRID_SIDE_W'(0));
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
    endtask

    task automatic test_extreme_samples();
        write_grid_side(GRID_SIDE_W'(2));
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_largest_grid();
        write_grid_side(GRID_SIDE_W'(63));
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = 1'b1;
        repeat (LARGE_ROWS * GRID_MAX) send_sample(random_sample());
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_random_frames();
        int                     sent;
        int                     count;
        int                     side;
        logic [GRID_SIDE_W-1:0] setting;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: setting = GRID_SIDE_W'($urandom_range(0, 1));
                1: setting = GRID_SIDE_W'($urandom_range(GRID_MAX + 1, 63));
                2: setting = GRID_SIDE_W'($urandom_range(9, GRID_MAX));
                default: setting = GRID_SIDE_W'($urandom_range(MIN_SIDE, 6));
            endcase
            side = (setting < MIN_SIDE) ? MIN_SIDE :
                   (setting > GRID_MAX) ? GRID_MAX : int'(setting);
            if (side > 8)
                count = $urandom_range(side, 3 * side);
            else if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, side * side);
            else
                count = side * side * $urandom_range(1, 3);
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            write_grid_side(setting);
            repeat (count) send_sample(random_sample());
            sent += count;
        end
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_default();
        test_restart_mid_frame();
        test_extreme_samples();
        test_largest_grid();
        test_random_frames();
        push <= 1'b0;
        for (waited = 0; pending_points.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            $display("%0d expected words never arrived", pending_points.size());
            mismatches += pending_points.size();
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
